### design/percent_url_decoder_unit_defines.svh
// Assertion macros for the percent URL decoder.
// Included by the top level; no other dependencies.
`ifndef PERCENT_URL_DECODER_UNIT_DEFINES_SVH
`define PERCENT_URL_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PUD_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PUD_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

### design/pud_pkg.sv
// Shared types, character constants and hex helpers for the percent URL decoder.
// No dependencies.
`timescale 1ns / 1ps

package pud_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } enc_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } dec_item_t;

    // Results caused by one input transfer, oldest in data[0].
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        logic [MAX_RESULTS-1:0][7:0]     data;
        logic                            last;
    } bundle_t;

    typedef struct packed {
        logic percent_seen;
        logic digit_held;
    } dec_status_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic digit;
        logic upper;
        logic lower;
        digit = (c >= 8'h30) && (c <= 8'h39);
        upper = (c >= 8'h41) && (c <= 8'h46);
        lower = (c >= 8'h61) && (c <= 8'h66);
        return digit || upper || lower;
    endfunction

    // Valid only for hex digits: letters have bit 6 set and low nibble 1..6.
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = c[6] ? (c[3:0] + 4'd9) : c[3:0];
        return v;
    endfunction

    function automatic bundle_t append(input bundle_t b, input logic [7:0] x);
        bundle_t r;
        r = b;
        r.data[b.cnt[1:0]] = x;
        r.cnt = b.cnt + CNT_W'(1);
        return r;
    endfunction

endpackage

### design/percent_url_decoder_unit.sv
// Percent URL decoder top level: decode logic feeding a result buffer.
// Depends on pud_pkg, pud_decode, pud_out_buffer and the assertion macro header.
//
// Usage:
//   enc channel (enc_valid / enc_stall / enc_item) takes one encoded byte per
//   transfer, in_last set on the final byte of a string.
//   dec channel (dec_valid / dec_stall / dec_item) returns decoded bytes in
//   order; run_last marks the last result of one input byte, string_end the
//   final byte of a string.
//   A byte yields zero to three results. With the output register free, its
//   first result appears on dec the cycle after its transfer; further results
//   follow one per cycle while dec_stall is low.
//   With dec_stall low, throughput is one input byte per cycle while each
//   byte yields at most one result; a byte with k results holds the output
//   register until all k are taken. enc_stall is a registered flag: it rises
//   only when a second bundle of results is parked behind the output register.
//   While dec_stall is high the output holds its result; one more byte with
//   results is parked (bytes without results still pass), then enc_stall stays
//   high until the parked bundle moves into the output register.
//   Reset clears any pending '%' escape and empties the result buffer.
`timescale 1ns / 1ps
`include "percent_url_decoder_unit_defines.svh"

module percent_url_decoder_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                enc_valid,
    output logic                enc_stall,
    input  pud_pkg::enc_item_t  enc_item,
    output logic                dec_valid,
    input  logic                dec_stall,
    output pud_pkg::dec_item_t  dec_item
);

    logic                 accept;
    logic                 full;
    pud_pkg::bundle_t     bundle;
    pud_pkg::dec_status_t status;

    assign enc_stall = full;
    assign accept    = enc_valid && !enc_stall;

    pud_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (enc_item),
        .bundle (bundle),
        .status (status)
    );

    pud_out_buffer u_out_buffer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (bundle.cnt != '0)),
        .bundle    (bundle),
        .full      (full),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_item  (dec_item)
    );

    `PUD_ASSERT_IMPLY(a_stall_needs_output, clk, rst_n,
        enc_stall, dec_valid, "stall without pending output")
    `PUD_ASSERT_IMPLY(a_digit_needs_percent, clk, rst_n,
        status.digit_held, status.percent_seen, "digit held without percent")
    `PUD_ASSERT_NEXT(a_last_clears_state, clk, rst_n,
        accept && enc_item.in_last, !status.percent_seen && !status.digit_held,
        "escape pending after end of string")

endmodule

### design/pud_decode.sv
// Decoder state and per-transfer result logic: one input byte -> up to three results.
// Depends on pud_pkg.
`timescale 1ns / 1ps

module pud_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  pud_pkg::enc_item_t    item,
    output pud_pkg::bundle_t      bundle,
    output pud_pkg::dec_status_t  status
);

    logic       percent_seen_reg;
    logic       percent_seen_next;
    logic       digit_held_reg;
    logic       digit_held_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;

    logic       fresh_pct;
    logic [7:0] fresh_byte;
    logic [7:0] b;

    assign b          = item.in_byte;
    assign fresh_pct  = (b == pud_pkg::CHAR_PERCENT);
    assign fresh_byte = (b == pud_pkg::CHAR_PLUS) ? pud_pkg::CHAR_SPACE : b;

    always_comb
    begin
        bundle            = '0;
        percent_seen_next = percent_seen_reg;
        digit_held_next   = digit_held_reg;
        held_byte_next    = held_byte_reg;

        if (!percent_seen_reg)
        begin
            if (fresh_pct)
                percent_seen_next = 1'b1;
            else
                bundle = pud_pkg::append(bundle, fresh_byte);
        end
        else if (!digit_held_reg)
        begin
            if (pud_pkg::is_hex(b))
            begin
                digit_held_next = 1'b1;
                held_byte_next  = b;
            end
            else
            begin
                percent_seen_next = 1'b0;
                bundle = pud_pkg::append(bundle, pud_pkg::CHAR_PERCENT);
                if (fresh_pct)
                    percent_seen_next = 1'b1;
                else
                    bundle = pud_pkg::append(bundle, fresh_byte);
            end
        end
        else
        begin
            percent_seen_next = 1'b0;
            digit_held_next   = 1'b0;
            if (pud_pkg::is_hex(held_byte_reg) && pud_pkg::is_hex(b))
            begin
                bundle = pud_pkg::append(bundle,
                    {pud_pkg::hex_nibble(held_byte_reg), pud_pkg::hex_nibble(b)});
            end
            else
            begin
                bundle = pud_pkg::append(bundle, pud_pkg::CHAR_PERCENT);
                bundle = pud_pkg::append(bundle, held_byte_reg);
                if (fresh_pct)
                    percent_seen_next = 1'b1;
                else
                    bundle = pud_pkg::append(bundle, fresh_byte);
            end
        end

        // end of string: flush pending escape literally
        if (item.in_last)
        begin
            if (percent_seen_next)
                bundle = pud_pkg::append(bundle, pud_pkg::CHAR_PERCENT);
            if (digit_held_next)
                bundle = pud_pkg::append(bundle, held_byte_next);
            percent_seen_next = 1'b0;
            digit_held_next   = 1'b0;
        end

        bundle.last = item.in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            percent_seen_reg <= 1'b0;
            digit_held_reg   <= 1'b0;
        end
        else if (accept)
        begin
            percent_seen_reg <= percent_seen_next;
            digit_held_reg   <= digit_held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            held_byte_reg <= held_byte_next;
    end

    assign status.percent_seen = percent_seen_reg;
    assign status.digit_held   = digit_held_reg;

endmodule

### design/pud_out_buffer.sv
// Result buffer: skid register for one bundle plus an output register that
// shifts out one result per transfer. Depends on pud_pkg.
`timescale 1ns / 1ps

module pud_out_buffer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pud_pkg::bundle_t    bundle,
    output logic                full,
    output logic                dec_valid,
    input  logic                dec_stall,
    output pud_pkg::dec_item_t  dec_item
);

    pud_pkg::bundle_t ser_reg;
    pud_pkg::bundle_t ser_next;
    pud_pkg::bundle_t skid_reg;
    pud_pkg::bundle_t skid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;

    logic out_fire;
    logic ser_free;

    assign dec_valid = (ser_reg.cnt != '0);
    assign out_fire  = dec_valid && !dec_stall;
    assign ser_free  = !dec_valid || (out_fire && (ser_reg.cnt == pud_pkg::CNT_W'(1)));
    assign full      = skid_valid_reg;

    always_comb
    begin
        ser_next        = ser_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (out_fire)
        begin
            ser_next.data = {8'h00, ser_reg.data[pud_pkg::MAX_RESULTS-1:1]};
            ser_next.cnt  = ser_reg.cnt - pud_pkg::CNT_W'(1);
        end

        if (ser_free)
        begin
            if (skid_valid_reg)
            begin
                ser_next        = skid_reg;
                skid_valid_next = 1'b0;
                if (push)
                begin
                    skid_next       = bundle;
                    skid_valid_next = 1'b1;
                end
            end
            else if (push)
            begin
                ser_next = bundle;
            end
        end
        else if (push)
        begin
            skid_next       = bundle;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_reg        <= '0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            ser_reg        <= ser_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid_reg <= skid_next;
    end

    assign dec_item.out_byte   = ser_reg.data[0];
    assign dec_item.run_last   = (ser_reg.cnt == pud_pkg::CNT_W'(1));
    assign dec_item.string_end = dec_item.run_last && ser_reg.last;

endmodule

### test/percent_url_decoder_unit_tb.sv
// Testbench for percent_url_decoder_unit: directed and random encoded strings under
// several pacing phases, checked against a built-in decoder predictor.
// Depends on pud_pkg and the percent_url_decoder_unit RTL.
`timescale 1ns / 1ps

module percent_url_decoder_unit_tb;

    class dec_scoreboard;
        pud_pkg::dec_item_t expected_q[$];
        pud_pkg::dec_item_t run_q[$];
        bit                 pct_pending;
        bit                 digit_pending;
        logic [7:0]         held_digit;
        int                 errors;
        int                 checked;

        function int hex_of(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            return -1;
        endfunction

        function void emit_byte(logic [7:0] b);
            pud_pkg::dec_item_t r;
            r.out_byte   = b;
            r.run_last   = 1'b0;
            r.string_end = 1'b0;
            if (run_q.size() < pud_pkg::MAX_RESULTS)
                run_q.push_back(r);
        endfunction

        function void take_fresh(logic [7:0] b);
            if (b == pud_pkg::CHAR_PERCENT)
                pct_pending = 1'b1;
            else if (b == pud_pkg::CHAR_PLUS)
                emit_byte(pud_pkg::CHAR_SPACE);
            else
                emit_byte(b);
        endfunction

        function void note_input(pud_pkg::enc_item_t it);
            int hi;
            int lo;
            run_q.delete();
            if (!pct_pending)
            begin
                take_fresh(it.in_byte);
            end
            else if (!digit_pending)
            begin
                if (hex_of(it.in_byte) >= 0)
                begin
                    digit_pending = 1'b1;
                    held_digit    = it.in_byte;
                end
                else
                begin
                    pct_pending = 1'b0;
                    emit_byte(pud_pkg::CHAR_PERCENT);
                    take_fresh(it.in_byte);
                end
            end
            else
            begin
                hi = hex_of(held_digit);
                lo = hex_of(it.in_byte);
                pct_pending   = 1'b0;
                digit_pending = 1'b0;
                if (hi >= 0 && lo >= 0)
                begin
                    emit_byte({hi[3:0], lo[3:0]});
                end
                else
                begin
                    emit_byte(pud_pkg::CHAR_PERCENT);
                    emit_byte(held_digit);
                    take_fresh(it.in_byte);
                end
            end
            if (it.in_last)
            begin
                if (pct_pending)
                    emit_byte(pud_pkg::CHAR_PERCENT);
                if (digit_pending)
                    emit_byte(held_digit);
                pct_pending   = 1'b0;
                digit_pending = 1'b0;
            end
            if (run_q.size() > 0)
            begin
                run_q[run_q.size() - 1].run_last   = 1'b1;
                run_q[run_q.size() - 1].string_end = it.in_last;
            end
            foreach (run_q[i])
                expected_q.push_back(run_q[i]);
        endfunction

        function void check_result(pud_pkg::dec_item_t got);
            pud_pkg::dec_item_t exp_item;
            if (expected_q.size() == 0)
            begin
                $error("unexpected decoded byte %02h", got.out_byte);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            checked++;
            if (got.out_byte !== exp_item.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", exp_item.out_byte, got.out_byte);
                errors++;
            end
            if (got.run_last !== exp_item.run_last)
            begin
                $error("run_last: expected %0b, got %0b", exp_item.run_last, got.run_last);
                errors++;
            end
            if (got.string_end !== exp_item.string_end)
            begin
                $error("string_end: expected %0b, got %0b",
                       exp_item.string_end, got.string_end);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               enc_valid = 1'b0;
    logic               enc_stall;
    pud_pkg::enc_item_t enc_item  = '0;
    logic               dec_valid;
    logic               dec_stall = 1'b0;
    pud_pkg::dec_item_t dec_item;

    dec_scoreboard sb = new();
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int bytes_sent    = 0;
    int strings_sent  = 0;

    percent_url_decoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enc_valid (enc_valid),
        .enc_stall (enc_stall),
        .enc_item  (enc_item),
        .dec_valid (dec_valid),
        .dec_stall (dec_stall),
        .dec_item  (dec_item)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        dec_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && dec_valid && !dec_stall)
            sb.check_result(dec_item);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        pud_pkg::enc_item_t it;
        it.in_byte = b;
        it.in_last = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            enc_valid <= 1'b0;
            @(negedge clk);
        end
        enc_valid <= 1'b1;
        enc_item  <= it;
        @(posedge clk);
        while (enc_stall)
            @(posedge clk);
        sb.note_input(it);
        bytes_sent++;
        if (last)
            strings_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // hold off the sender until every expected byte is out or the wait limit is reached
    task automatic drain();
        int waited;
        waited = 0;
        enc_valid <= 1'b0;
        while (sb.expected_q.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(21);
        if (r < 10)
            return 8'("0" + r);
        if (r < 16)
            return 8'("a" + r - 10);
        return 8'("A" + r - 16);
    endfunction

    function automatic logic [7:0] rand_nonhex();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (sb.hex_of(b) >= 0)
            b = 8'($urandom_range(255));
        return b;
    endfunction

    task automatic send_random_string();
        logic [7:0] q[$];
        int segs;
        int r;
        segs = $urandom_range(6, 1);
        for (int s = 0; s < segs; s++)
        begin
            r = $urandom_range(99);
            if (r < 45)
            begin
                q.push_back(pud_pkg::CHAR_PERCENT);
                q.push_back(rand_hex());
                q.push_back(rand_hex());
            end
            else if (r < 58)
            begin
                q.push_back(pud_pkg::CHAR_PLUS);
            end
            else if (r < 80)
            begin
                q.push_back(8'($urandom_range(8'h7E, 8'h20)));
            end
            else if (r < 86)
            begin
                q.push_back(pud_pkg::CHAR_PERCENT);
                q.push_back(rand_nonhex());
            end
            else if (r < 92)
            begin
                q.push_back(pud_pkg::CHAR_PERCENT);
                q.push_back(rand_hex());
                q.push_back(rand_nonhex());
            end
            else
            begin
                q.push_back(8'($urandom_range(255)));
            end
        end
        // sometimes end mid-escape
        if ($urandom_range(9) == 0)
            q.push_back(pud_pkg::CHAR_PERCENT);
        else if ($urandom_range(9) == 0)
        begin
            q.push_back(pud_pkg::CHAR_PERCENT);
            q.push_back(rand_hex());
        end
        foreach (q[i])
            send_byte(q[i], i == q.size() - 1);
    endtask

    initial
    begin
        #3_000_000;
        $display("FAIL percent_url_decoder_unit");
        $finish;
    end

    initial
    begin
        int target;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text("%41");
        send_text("%6f+");
        send_text("%g");
        send_text("%4x");
        send_text("%%");
        send_text("%4");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%4%");
        send_text("%A+");
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 73;
                end
                default:
                begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                end
            endcase
            target = bytes_sent + 33;
            while (bytes_sent < target)
                send_random_string();
            drain();
        end

        if (sb.expected_q.size() != 0)
        begin
            $error("%0d decoded bytes never arrived", sb.expected_q.size());
            sb.errors++;
        end
        $display("Sent %0d encoded bytes in %0d strings across four pacing phases;",
                 bytes_sent, strings_sent);
        $display("checked %0d decoded bytes.", sb.checked);
        if (sb.errors == 0)
            $display("PASS percent_url_decoder_unit");
        else
            $display("FAIL percent_url_decoder_unit");
        $finish;
    end

endmodule
